/* hdl/tof_pkg.sv */
// package: payload types, status codes, constants and arithmetic helpers for the budget calculator
`default_nettype none
package tof_pkg;

    // fixed overheads in microseconds
    localparam logic [31:0] OVH_START  = 32'd1910;
    localparam logic [31:0] OVH_END    = 32'd960;
    localparam logic [31:0] OVH_MSRC   = 32'd660;
    localparam logic [31:0] OVH_TCC    = 32'd590;
    localparam logic [31:0] OVH_DSS    = 32'd690;
    localparam logic [31:0] OVH_PRE    = 32'd660;
    localparam logic [31:0] OVH_FINAL  = 32'd550;
    localparam logic [31:0] MIN_BUDGET = 32'd20000;
    localparam logic [31:0] ROUND_HALF = 32'd500;
    localparam logic [31:0] US_TO_NS   = 32'd1000;

    // step enable bit positions
    localparam int EN_MSRC  = 2;
    localparam int EN_DSS   = 3;
    localparam int EN_TCC   = 4;
    localparam int EN_PRE   = 6;
    localparam int EN_FINAL = 7;

    // macro period: 2304*1655/1000 = 3813.12 ns per pll clock
    localparam logic [21:0] MACRO_NS_INT = 22'd3813;
    localparam logic [21:0] RECIP_50     = 22'd1311;

    // x / 1000 for any 32-bit x as a multiply and shift
    localparam logic [63:0] DIV1000_MAGIC = 64'h0000_0000_1062_4DD3;
    localparam int          DIV1000_SHIFT = 38;

    // divider geometry
    localparam int DIV_W = 32;
    localparam int DEN_W = 20;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BELOW_MIN   = 3'd1,
        ST_TOO_SMALL   = 3'd2,
        ST_FINAL_OFF   = 3'd3,
        ST_ZERO_PERIOD = 3'd4
    } t_status;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  sequence_enables;
        logic [7:0]  pre_period_pclks;
        logic [7:0]  final_period_pclks;
        logic [7:0]  msrc_timeout_byte;
        logic [15:0] pre_timeout_word;
        logic [15:0] final_timeout_word;
        logic [21:0] requested_budget_us;
    } t_in_word;

    typedef struct packed {
        logic [31:0] budget_us;
        logic [15:0] new_timeout_word;
        logic        write_timeout;
        t_status     status;
    } t_out_word;

    // sideband that rides along the divider
    typedef struct packed {
        t_out_word   res;
        logic        do_div;
        logic        pre_on;
        logic [15:0] pre_mclks;
    } t_side;

    // timeout word to macro periods, wraps at 16 bits
    function automatic logic [15:0] mclks_of_word(input logic [15:0] w);
        logic [15:0] v;
        v = (w[15:8] < 8'd16) ? ({8'd0, w[7:0]} << w[11:8]) : 16'd0;
        return v + 16'd1;
    endfunction

    // rounded macro period in ns for a period in pll clocks
    function automatic logic [19:0] vcsel_period_ns(input logic [7:0] p);
        logic [21:0] base;
        logic [10:0] x;
        logic [21:0] corr;
        base = 22'(p) * MACRO_NS_INT;
        x    = 11'(p) * 11'd6 + 11'd25;
        corr = (22'(x) * RECIP_50) >> 16;
        return 20'(base + corr);
    endfunction

    // unsigned 32-bit divide by 1000
    function automatic logic [31:0] div1000(input logic [31:0] x);
        logic [63:0] prod;
        prod = 64'(x) * DIV1000_MAGIC;
        return 32'(prod >> DIV1000_SHIFT);
    endfunction

endpackage
`default_nettype wire

/* hdl/tof_stream_if.sv */
// interface: valid/ready channel carrying one word
`default_nettype none
interface tof_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/tof_div.sv */
// pipelined restoring divider, one quotient bit per stage, sideband carried along
`default_nettype none
module tof_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [tof_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [tof_pkg::DEN_W-1:0]   i_divisor,
    input  wire tof_pkg::t_side              i_side,
    output logic                             o_valid,
    output logic [tof_pkg::DIV_W-1:0]        o_quotient,
    output tof_pkg::t_side                   o_side
);
    localparam int NW = tof_pkg::DIV_W;
    localparam int DW = tof_pkg::DEN_W;

    logic                r_v    [NW];
    logic [DW-1:0]       r_rem  [NW];
    logic [NW-1:0]       r_num  [NW];
    logic [NW-1:0]       r_q    [NW];
    logic [DW-1:0]       r_den  [NW];
    tof_pkg::t_side      r_side [NW];

    genvar s;
    generate
        for (s = 0; s < NW; s++) begin : g_stage
            logic           p_v;
            logic [DW-1:0]  p_rem;
            logic [NW-1:0]  p_num;
            logic [NW-1:0]  p_q;
            logic [DW-1:0]  p_den;
            tof_pkg::t_side p_side;
            logic [DW:0]    trial;
            logic           ge;
            logic [DW-1:0]  n_rem;

            // previous stage or pipeline entry
            if (s == 0) begin : g_first
                assign p_v    = i_valid;
                assign p_rem  = '0;
                assign p_num  = i_dividend;
                assign p_q    = '0;
                assign p_den  = i_divisor;
                assign p_side = i_side;
            end else begin : g_next
                assign p_v    = r_v[s-1];
                assign p_rem  = r_rem[s-1];
                assign p_num  = r_num[s-1];
                assign p_q    = r_q[s-1];
                assign p_den  = r_den[s-1];
                assign p_side = r_side[s-1];
            end

            // shift in next dividend bit, subtract when it fits
            always_comb begin
                trial = {p_rem, p_num[NW-1]};
                ge    = (trial >= {1'b0, p_den});
                n_rem = ge ? DW'(trial - {1'b0, p_den}) : DW'(trial);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (i_en) begin
                    r_v[s] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= n_rem;
                    r_num[s]  <= p_num << 1;
                    r_q[s]    <= {p_q[NW-2:0], ge};
                    r_den[s]  <= p_den;
                    r_side[s] <= p_side;
                end
            end
        end
    endgenerate

    assign o_valid    = r_v[NW-1];
    assign o_quotient = r_q[NW-1];
    assign o_side     = r_side[NW-1];

endmodule
`default_nettype wire

/* hdl/tof_timing_budget_calc_unit.sv */
// top level: time-of-flight timing budget calculator
// One query word in, one result word out, fully pipelined: a new word is taken every
// cycle unless the output stalls, and each result passes through seven arithmetic stages,
// a 32-stage restoring divider that produces one quotient bit per stage, and four
// stages that add back the pre-range periods and encode the timeout word. A stall
// on the output freezes the whole pipeline in place; while a finished word waits in
// the result register the input is held off, so input ready follows output ready.
`default_nettype none
module tof_timing_budget_calc_unit (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    tof_stream_if.sink     i_in,
    tof_stream_if.source   o_out
);
    localparam int NW = tof_pkg::DIV_W;
    localparam int DW = tof_pkg::DEN_W;

    logic                 r_v_out;
    tof_pkg::t_out_word   r_out;
    logic                 w_adv;
    tof_pkg::t_in_word    w_in;

    // whole pipeline advances when the output slot is free or being taken
    assign w_adv       = !r_v_out || o_out.ready;
    assign i_in.ready  = w_adv;
    assign w_in        = i_in.data;
    assign o_out.valid = r_v_out;
    assign o_out.data  = r_out;

    // stage 1: decode timeout words and macro periods
    logic                 r1_v;
    tof_pkg::t_in_word    r1_in;
    logic [DW-1:0]        r1_mns_pre, r1_mns_fin;
    logic [15:0]          r1_pre_mclks, r1_fin_mclks;
    logic [15:0]          w_pre_dec, w_fin_dec;

    always_comb begin
        w_pre_dec = tof_pkg::mclks_of_word(w_in.pre_timeout_word);
        w_fin_dec = tof_pkg::mclks_of_word(w_in.final_timeout_word);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_in        <= w_in;
            r1_mns_pre   <= tof_pkg::vcsel_period_ns(w_in.pre_period_pclks);
            r1_mns_fin   <= tof_pkg::vcsel_period_ns(w_in.final_period_pclks);
            r1_pre_mclks <= w_pre_dec;
            r1_fin_mclks <= w_in.sequence_enables[tof_pkg::EN_PRE] ?
                            16'(w_fin_dec - w_pre_dec) : w_fin_dec;
        end
    end

    // stage 2: periods times macro period, plus rounding half
    logic                 r2_v;
    tof_pkg::t_in_word    r2_in;
    logic [DW-1:0]        r2_mns_fin;
    logic [15:0]          r2_pre_mclks;
    logic [31:0]          r2_p_msrc, r2_p_pre, r2_p_fin;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_in        <= r1_in;
            r2_mns_fin   <= r1_mns_fin;
            r2_pre_mclks <= r1_pre_mclks;
            r2_p_msrc    <= 32'(29'(9'(r1_in.msrc_timeout_byte) + 9'd1) * 29'(r1_mns_pre))
                            + tof_pkg::ROUND_HALF;
            r2_p_pre     <= 32'(36'(r1_pre_mclks) * 36'(r1_mns_pre)) + tof_pkg::ROUND_HALF;
            r2_p_fin     <= 32'(36'(r1_fin_mclks) * 36'(r1_mns_fin)) + tof_pkg::ROUND_HALF;
        end
    end

    // stage 3: ns to us
    logic                 r3_v;
    tof_pkg::t_in_word    r3_in;
    logic [DW-1:0]        r3_mns_fin;
    logic [15:0]          r3_pre_mclks;
    logic [31:0]          r3_us_msrc, r3_us_pre, r3_us_fin;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_in        <= r2_in;
            r3_mns_fin   <= r2_mns_fin;
            r3_pre_mclks <= r2_pre_mclks;
            r3_us_msrc   <= tof_pkg::div1000(r2_p_msrc);
            r3_us_pre    <= tof_pkg::div1000(r2_p_pre);
            r3_us_fin    <= tof_pkg::div1000(r2_p_fin);
        end
    end

    // stage 4: per-step terms
    logic                 r4_v;
    tof_pkg::t_in_word    r4_in;
    logic [DW-1:0]        r4_mns_fin;
    logic [15:0]          r4_pre_mclks;
    logic [31:0]          r4_t_tcc, r4_t_dm, r4_t_pre, r4_t_fin;
    logic [7:0]           w_en3;

    assign w_en3 = r3_in.sequence_enables;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_in        <= r3_in;
            r4_mns_fin   <= r3_mns_fin;
            r4_pre_mclks <= r3_pre_mclks;
            r4_t_tcc     <= w_en3[tof_pkg::EN_TCC] ? r3_us_msrc + tof_pkg::OVH_TCC : '0;
            if (w_en3[tof_pkg::EN_DSS]) begin
                r4_t_dm <= (r3_us_msrc + tof_pkg::OVH_DSS) << 1;
            end else if (w_en3[tof_pkg::EN_MSRC]) begin
                r4_t_dm <= r3_us_msrc + tof_pkg::OVH_MSRC;
            end else begin
                r4_t_dm <= '0;
            end
            r4_t_pre     <= w_en3[tof_pkg::EN_PRE] ? r3_us_pre + tof_pkg::OVH_PRE : '0;
            r4_t_fin     <= w_en3[tof_pkg::EN_FINAL] ? r3_us_fin + tof_pkg::OVH_FINAL : '0;
        end
    end

    // stage 5: common used time
    logic                 r5_v;
    tof_pkg::t_in_word    r5_in;
    logic [DW-1:0]        r5_mns_fin;
    logic [15:0]          r5_pre_mclks;
    logic [31:0]          r5_used, r5_t_fin;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_in        <= r4_in;
            r5_mns_fin   <= r4_mns_fin;
            r5_pre_mclks <= r4_pre_mclks;
            r5_used      <= tof_pkg::OVH_START + tof_pkg::OVH_END + r4_t_tcc + r4_t_dm
                            + r4_t_pre;
            r5_t_fin     <= r4_t_fin;
        end
    end

    // stage 6: budget result or checks for the request
    logic                 r6_v;
    tof_pkg::t_side       r6_side;
    logic [DW-1:0]        r6_mns_fin;
    logic [31:0]          r6_diff;
    tof_pkg::t_side       n6_side;
    logic [31:0]          w_used1, w_req;

    always_comb begin
        w_used1           = r5_used + tof_pkg::OVH_FINAL;
        w_req             = 32'(r5_in.requested_budget_us);
        n6_side           = '0;
        n6_side.pre_on    = r5_in.sequence_enables[tof_pkg::EN_PRE];
        n6_side.pre_mclks = r5_pre_mclks;
        if (!r5_in.opcode) begin
            n6_side.res.budget_us = r5_used + r5_t_fin;
        end else if (w_req < tof_pkg::MIN_BUDGET) begin
            n6_side.res.status = tof_pkg::ST_BELOW_MIN;
        end else if (!r5_in.sequence_enables[tof_pkg::EN_FINAL]) begin
            n6_side.res.status = tof_pkg::ST_FINAL_OFF;
        end else if (w_used1 > w_req) begin
            n6_side.res.status = tof_pkg::ST_TOO_SMALL;
        end else if (r5_mns_fin == '0) begin
            n6_side.res.status = tof_pkg::ST_ZERO_PERIOD;
        end else begin
            n6_side.do_div = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_side    <= n6_side;
            r6_mns_fin <= r5_mns_fin;
            r6_diff    <= w_req - w_used1;
        end
    end

    // stage 7: scaled dividend with rounding half of the divisor
    logic                 r7_v;
    tof_pkg::t_side       r7_side;
    logic [DW-1:0]        r7_mns_fin;
    logic [NW-1:0]        r7_dividend;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_side     <= r6_side;
            r7_mns_fin  <= r6_mns_fin;
            r7_dividend <= 32'(r6_diff * tof_pkg::US_TO_NS) + 32'(r6_mns_fin >> 1);
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    // remaining time over final macro period
    logic                 w_dv_v;
    logic [NW-1:0]        w_q;
    tof_pkg::t_side       w_dv_side;

    tof_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r7_v),
        .i_dividend (r7_dividend),
        .i_divisor  (r7_mns_fin),
        .i_side     (r7_side),
        .o_valid    (w_dv_v),
        .o_quotient (w_q),
        .o_side     (w_dv_side)
    );

    // post 1: add back pre-range periods
    logic                 r8_v;
    tof_pkg::t_side       r8_side;
    logic [31:0]          r8_m;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_side <= w_dv_side;
            r8_m    <= w_q + (w_dv_side.pre_on ? 32'(w_dv_side.pre_mclks) : 32'd0);
        end
    end

    // post 2: periods minus one
    logic                 r9_v;
    tof_pkg::t_side       r9_side;
    logic [31:0]          r9_ls;
    logic                 r9_mzero;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_side  <= r8_side;
            r9_ls    <= r8_m - 32'd1;
            r9_mzero <= (r8_m == '0);
        end
    end

    // post 3: exponent from the leading one
    logic                 r10_v;
    tof_pkg::t_side       r10_side;
    logic [31:0]          r10_ls;
    logic                 r10_mzero;
    logic [4:0]           r10_ms;
    logic [4:0]           n10_ms;

    always_comb begin
        n10_ms = '0;
        for (int i = 8; i < 32; i++) begin
            if (r9_ls[i]) begin
                n10_ms = 5'(i - 7);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_side  <= r9_side;
            r10_ls    <= r9_ls;
            r10_mzero <= r9_mzero;
            r10_ms    <= n10_ms;
        end
    end

    // post 4: encode and load the result register
    tof_pkg::t_out_word   n_out;
    logic [31:0]          w_mant;

    always_comb begin
        w_mant = r10_ls >> r10_ms;
        n_out  = r10_side.res;
        if (r10_side.do_div) begin
            n_out.write_timeout    = 1'b1;
            n_out.new_timeout_word = r10_mzero ? 16'd0 : {3'd0, r10_ms, w_mant[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r10_v   <= 1'b0;
            r_v_out <= 1'b0;
        end else if (w_adv) begin
            r8_v    <= w_dv_v;
            r9_v    <= r8_v;
            r10_v   <= r9_v;
            r_v_out <= r10_v;
        end
    end

`ifndef NO_ASSERTIONS
    // a written timeout always carries ok status and no budget
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.write_timeout) |->
        (o_out.data.status == tof_pkg::ST_OK && o_out.data.budget_us == '0))
        else $error("timeout write with error status or budget");

    // encoded exponent never exceeds 24
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.write_timeout) |->
        (o_out.data.new_timeout_word[15:8] <= 8'd24))
        else $error("timeout exponent out of range");

    // an error status never comes with a timeout word
    a_err_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.status != tof_pkg::ST_OK) |->
        (!o_out.data.write_timeout && o_out.data.new_timeout_word == '0))
        else $error("error status with timeout word");

    // an accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r1_v)
        else $error("accepted word lost at pipeline entry");
`endif

endmodule
`default_nettype wire
